>>> hw/rtl/jax_pkg.sv
// Shared types and constants for the joystick axis normalizer.
package jax_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FULL_SCALE  = 1000;
    localparam int POS_BITS    = 11;
    localparam int FS_BITS     = $clog2(FULL_SCALE + 1);
    localparam int Q_BITS      = FS_BITS;
    localparam int PROD_BITS   = SAMPLE_BITS + FS_BITS;
    localparam int DIFF_BITS   = SAMPLE_BITS + 2;
    localparam int IDX_BITS    = 3;

    typedef enum logic [IDX_BITS-1:0] {
        REG_ENABLED   = 3'd0,
        REG_X_MINIMUM = 3'd1,
        REG_X_MAXIMUM = 3'd2,
        REG_X_CENTER  = 3'd3,
        REG_Y_MINIMUM = 3'd4,
        REG_Y_MAXIMUM = 3'd5,
        REG_Y_CENTER  = 3'd6,
        REG_DEAD_BAND = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic                   axis;
        logic [SAMPLE_BITS-1:0] raw_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0] position;
        logic                       in_dead_band;
        logic                       calib_error;
    } out_item_t;

    typedef struct packed {
        logic                   enabled;
        logic [SAMPLE_BITS-1:0] x_minimum;
        logic [SAMPLE_BITS-1:0] x_maximum;
        logic [SAMPLE_BITS-1:0] x_center;
        logic [SAMPLE_BITS-1:0] y_minimum;
        logic [SAMPLE_BITS-1:0] y_maximum;
        logic [SAMPLE_BITS-1:0] y_center;
        logic [SAMPLE_BITS-1:0] dead_band;
    } cfg_t;

    // Region and status flags that ride along with each word
    typedef struct packed {
        logic enabled;
        logic band;
        logic above;
        logic err;
        logic neg;
    } ctl_t;

    typedef struct packed {
        ctl_t                   ctl;
        logic [PROD_BITS-1:0]   num;
        logic [PROD_BITS-1:0]   lim;
        logic [SAMPLE_BITS-1:0] span;
    } mul_item_t;

    typedef struct packed {
        ctl_t              ctl;
        logic              sat;
        logic [Q_BITS-1:0] quo;
    } quo_item_t;

endpackage

>>> hw/rtl/jax_front.sv
// Front end: calibration select, region decode and scaling multiply (three stages).
module jax_front (
    input  logic               clk,
    input  logic               rst_n,
    input  jax_pkg::cfg_t      cfg,
    input  logic               up_valid,
    input  jax_pkg::in_item_t  up_data,
    output logic               up_load,
    output logic               down_valid,
    output jax_pkg::mul_item_t down_data,
    input  logic               down_load
);
    import jax_pkg::*;

    localparam logic [FS_BITS-1:0] FS_K = FS_BITS'(FULL_SCALE);

    logic                        v1_reg, v2_reg, v3_reg;
    logic                        ld1, ld2, ld3;

    logic                        en1_reg;
    logic [SAMPLE_BITS-1:0]      raw1_reg, lo1_reg, hi1_reg;
    logic [SAMPLE_BITS:0]        upper1_reg;
    logic signed [DIFF_BITS-1:0] lower1_reg;

    logic [SAMPLE_BITS-1:0]      lo_sel, hi_sel, mid_sel;
    logic [SAMPLE_BITS:0]        upper_next;
    logic signed [DIFF_BITS-1:0] lower_next;

    logic                        above, below;
    logic signed [DIFF_BITS-1:0] span_up, span_dn, span;
    ctl_t                        ctl_next;
    logic [SAMPLE_BITS-1:0]      diff_next;

    ctl_t                        ctl2_reg;
    logic [SAMPLE_BITS-1:0]      diff2_reg, span2_reg;

    mul_item_t                   s3_reg;
    logic [PROD_BITS-1:0]        num_next, lim_next;

    // Each stage takes a word when empty or when its successor takes one
    assign ld3     = !v3_reg || down_load;
    assign ld2     = !v2_reg || ld3;
    assign ld1     = !v1_reg || ld2;
    assign up_load = ld1;

    // Pick the axis calibration and the band edges
    always_comb
    begin
        lo_sel     = up_data.axis ? cfg.y_minimum : cfg.x_minimum;
        hi_sel     = up_data.axis ? cfg.y_maximum : cfg.x_maximum;
        mid_sel    = up_data.axis ? cfg.y_center  : cfg.x_center;
        upper_next = {1'b0, mid_sel} + {1'b0, cfg.dead_band};
        lower_next = $signed({2'b00, mid_sel}) - $signed({2'b00, cfg.dead_band});
    end

    // Decode region, divisor span and numerator offset
    always_comb
    begin
        above   = {1'b0, raw1_reg} > upper1_reg;
        below   = $signed({2'b00, raw1_reg}) < lower1_reg;
        span_up = $signed({2'b00, hi1_reg}) - $signed({1'b0, upper1_reg});
        span_dn = lower1_reg - $signed({2'b00, lo1_reg});
        span    = above ? span_up : span_dn;

        ctl_next.enabled = en1_reg;
        ctl_next.band    = !above && !below;
        ctl_next.above   = above;
        ctl_next.err     = (span <= $signed(DIFF_BITS'(0)));
        ctl_next.neg     = raw1_reg < lo1_reg;

        diff_next = above ? (raw1_reg - upper1_reg[SAMPLE_BITS-1:0]) : (raw1_reg - lo1_reg);
    end

    // Scale numerator and span by full scale
    assign num_next = PROD_BITS'(diff2_reg) * PROD_BITS'(FS_K);
    assign lim_next = PROD_BITS'(span2_reg) * PROD_BITS'(FS_K);

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= up_valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            en1_reg    <= cfg.enabled;
            raw1_reg   <= up_data.raw_sample;
            lo1_reg    <= lo_sel;
            hi1_reg    <= hi_sel;
            upper1_reg <= upper_next;
            lower1_reg <= lower_next;
        end
        if (ld2)
        begin
            ctl2_reg  <= ctl_next;
            diff2_reg <= diff_next;
            span2_reg <= span[SAMPLE_BITS-1:0];
        end
        if (ld3)
        begin
            s3_reg.ctl  <= ctl2_reg;
            s3_reg.num  <= num_next;
            s3_reg.lim  <= lim_next;
            s3_reg.span <= span2_reg;
        end
    end

    assign down_valid = v3_reg;
    assign down_data  = s3_reg;

endmodule

>>> hw/rtl/jax_div.sv
// Divider pipeline: saturation check, then one restoring quotient bit per stage.
module jax_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    input  jax_pkg::mul_item_t  up_data,
    output logic                up_load,
    output logic                down_valid,
    output jax_pkg::quo_item_t  down_data,
    input  logic                down_load
);
    import jax_pkg::*;

    typedef struct packed {
        ctl_t                   ctl;
        logic                   sat;
        logic [PROD_BITS-1:0]   rem;
        logic [SAMPLE_BITS-1:0] span;
        logic [Q_BITS-1:0]      quo;
    } div_stage_t;

    div_stage_t        st_reg [0:Q_BITS];
    logic [Q_BITS:0]   v_reg;
    logic [Q_BITS+1:0] ld;

    assign ld[Q_BITS+1] = down_load;
    assign up_load      = ld[0];

    genvar g;
    generate
        for (g = 0; g <= Q_BITS; g++)
        begin : g_stage
            assign ld[g] = !v_reg[g] || ld[g+1];

            // Advance valid bit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[g] <= 1'b0;
                end
                else if (ld[g])
                begin
                    v_reg[g] <= (g == 0) ? up_valid : v_reg[(g == 0) ? 0 : g-1];
                end
            end

            if (g == 0)
            begin : g_check
                div_stage_t st_next;

                // Flag quotients at or above full scale, load the remainder
                always_comb
                begin
                    st_next.ctl  = up_data.ctl;
                    st_next.sat  = up_data.num >= up_data.lim;
                    st_next.rem  = up_data.num;
                    st_next.span = up_data.span;
                    st_next.quo  = '0;
                end

                always_ff @(posedge clk)
                begin
                    if (ld[g])
                    begin
                        st_reg[g] <= st_next;
                    end
                end
            end
            else
            begin : g_bit
                logic [PROD_BITS-1:0] trial;
                logic                 fit;
                div_stage_t           st_next;

                // Try to subtract the span at this quotient weight
                always_comb
                begin
                    trial = {{(PROD_BITS-SAMPLE_BITS){1'b0}}, st_reg[g-1].span} << (Q_BITS-g);
                    fit   = st_reg[g-1].rem >= trial;
                    st_next = st_reg[g-1];
                    if (fit)
                    begin
                        st_next.rem = st_reg[g-1].rem - trial;
                    end
                    st_next.quo[Q_BITS-g] = fit;
                end

                always_ff @(posedge clk)
                begin
                    if (ld[g])
                    begin
                        st_reg[g] <= st_next;
                    end
                end
            end
        end
    endgenerate

    assign down_valid    = v_reg[Q_BITS];
    assign down_data.ctl = st_reg[Q_BITS].ctl;
    assign down_data.sat = st_reg[Q_BITS].sat;
    assign down_data.quo = st_reg[Q_BITS].quo;

endmodule

>>> hw/rtl/jax_out.sv
// Output stage: result assembly, saturation and the output register.
module jax_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    input  jax_pkg::quo_item_t up_data,
    output logic               up_load,
    output logic               out_valid,
    output jax_pkg::out_item_t out_data,
    input  logic               out_ready
);
    import jax_pkg::*;

    localparam logic signed [POS_BITS-1:0] FS_POS = POS_BITS'(FULL_SCALE);

    logic                       valid_reg;
    out_item_t                  data_reg;
    out_item_t                  data_next;
    logic signed [POS_BITS-1:0] quo_ext;

    assign up_load = !valid_reg || out_ready;
    assign quo_ext = $signed({{(POS_BITS-Q_BITS){1'b0}}, up_data.quo});

    // Build the result word
    always_comb
    begin
        data_next.position     = '0;
        data_next.in_dead_band = 1'b0;
        data_next.calib_error  = 1'b0;
        if (up_data.ctl.enabled)
        begin
            if (up_data.ctl.band)
            begin
                data_next.in_dead_band = 1'b1;
            end
            else if (up_data.ctl.err)
            begin
                data_next.calib_error = 1'b1;
            end
            else if (up_data.ctl.above)
            begin
                data_next.position = up_data.sat ? FS_POS : quo_ext;
            end
            else
            begin
                data_next.position = up_data.ctl.neg ? -FS_POS : (quo_ext - FS_POS);
            end
        end
    end

    // Hold the word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_load)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/joystick_axis_normalizer.sv
// Joystick axis normalizer: configuration registers and the full pipeline.
// Pipeline: 3 front stages, a saturation check and 10 quotient-bit stages of the divider,
// and 1 output stage.
// Throughput: one word per cycle while out_ready is high; any stage that is
// empty takes a new word even while a finished result waits at the output.
// Reset: valid bits clear and the configuration registers return to their defaults.
module joystick_axis_normalizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  jax_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output jax_pkg::out_item_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jax_pkg::IDX_BITS-1:0]        cfg_index,
    input  logic [jax_pkg::SAMPLE_BITS-1:0]     cfg_data
);
    import jax_pkg::*;

    cfg_t      cfg_reg;
    logic      front_valid, div_valid;
    logic      front_load, div_load, out_load;
    mul_item_t front_data;
    quo_item_t div_data;

    assign cfg_ready = 1'b1;

    // Register file writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled   <= 1'b0;
            cfg_reg.x_minimum <= SAMPLE_BITS'(0);
            cfg_reg.x_maximum <= SAMPLE_BITS'(4095);
            cfg_reg.x_center  <= SAMPLE_BITS'(2048);
            cfg_reg.y_minimum <= SAMPLE_BITS'(0);
            cfg_reg.y_maximum <= SAMPLE_BITS'(4095);
            cfg_reg.y_center  <= SAMPLE_BITS'(2048);
            cfg_reg.dead_band <= SAMPLE_BITS'(100);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_ENABLED:   cfg_reg.enabled   <= cfg_data[0];
                REG_X_MINIMUM: cfg_reg.x_minimum <= cfg_data;
                REG_X_MAXIMUM: cfg_reg.x_maximum <= cfg_data;
                REG_X_CENTER:  cfg_reg.x_center  <= cfg_data;
                REG_Y_MINIMUM: cfg_reg.y_minimum <= cfg_data;
                REG_Y_MAXIMUM: cfg_reg.y_maximum <= cfg_data;
                REG_Y_CENTER:  cfg_reg.y_center  <= cfg_data;
                REG_DEAD_BAND: cfg_reg.dead_band <= cfg_data;
                default:       cfg_reg.enabled   <= cfg_reg.enabled;
            endcase
        end
    end

    assign in_ready = front_load;

    jax_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .up_valid   (in_valid),
        .up_data    (in_data),
        .up_load    (front_load),
        .down_valid (front_valid),
        .down_data  (front_data),
        .down_load  (div_load)
    );

    jax_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (front_valid),
        .up_data    (front_data),
        .up_load    (div_load),
        .down_valid (div_valid),
        .down_data  (div_data),
        .down_load  (out_load)
    );

    jax_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (div_valid),
        .up_data   (div_data),
        .up_load   (out_load),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_ready (out_ready)
    );

endmodule
